/* hdl/sli_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sli_pkg: shared types and codes of the sorted insertion list
// Request action codes, result status codes and fixed field widths.
// ---------------------------------------------------------------------------
package sli_pkg;

  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 4;
  localparam int OUT_VAL_W   = 32;
  localparam int OUT_CNT_W   = 5;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_DUMP   = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD_POS = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_DUMP    = 3'd4
  } status_t;

endpackage
`default_nettype wire

/* hdl/sorted_list_insert_remove.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_list_insert_remove: bounded sorted list with insert, remove, dump
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// ---------------------------------------------------------------------------
// order: a request is registered, then worked in one pass into the result
//   register; the request stage waits while an untaken result is held
// throughput: one insert, remove or empty dump per cycle while results are
//   taken; a dump of a non-empty list holds the request stage until every
//   entry, one per result, has gone out through the single result register
// reset (rst_n, synchronous): clears count and all valid flags; cell
//   contents are not cleared, only entries below count are ever sent out
module sorted_list_insert_remove #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // request channel
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // in_tdata fields, lowest bit up: value[VALUE_BITS], position[4], zero pad
  input  wire  [((VALUE_BITS+sli_pkg::POS_W+7)/8)*8-1:0] in_tdata,
  // in_tuser fields: action[2]
  input  wire  [sli_pkg::ACTION_W-1:0]      in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // out_tdata fields, lowest bit up: entry_value[32], entry_count[5], zero pad
  output logic [sli_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser fields: status[3]
  output sli_pkg::status_t                  out_tuser,
  output logic                              out_tlast
);
  import sli_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int PAD_W = OUT_DATA_W - OUT_VAL_W - OUT_CNT_W;

  // request register
  logic                         req_valid_r;
  logic [ACTION_W-1:0]          req_action_r;
  logic signed [VALUE_BITS-1:0] req_value_r;
  logic [POS_W-1:0]             req_pos_r;

  // list state
  logic signed [VALUE_BITS-1:0] cells_r   [CAPACITY];
  logic signed [VALUE_BITS-1:0] cells_nxt [CAPACITY];
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             dump_cnt_r, dump_cnt_nxt;

  // result register
  logic                         out_valid_r;
  status_t                      out_status_r, out_status_nxt;
  logic [OUT_VAL_W-1:0]         out_value_r, out_value_nxt;
  logic [OUT_CNT_W-1:0]         out_count_r;
  logic                         out_last_r, out_last_nxt;

  logic                         fire;      // request worked this cycle
  logic                         req_done;  // request leaves the stage
  logic                         le        [CAPACITY];
  logic [CNT_W-1:0]             cnt_m1;
  logic                         dump_last;
  logic [CMP_W-1:0]             pos_ext, cnt_ext;
  logic [VALUE_BITS-1:0]        head_raw;

  assign fire      = req_valid_r && (!out_valid_r || out_tready);
  assign cnt_m1    = count_r - 1'b1;
  assign dump_last = (dump_cnt_r == cnt_m1);
  assign pos_ext   = CMP_W'(req_pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  // head cell as plain bits, later zero-extended or cut to the result width
  assign head_raw  = cells_r[0];

  // a non-empty dump stays until its final entry goes out
  assign req_done  = fire && !((action_t'(req_action_r) == ACT_DUMP) &&
                               (count_r != '0) && !dump_last);
  assign in_tready = !req_valid_r || req_done;

  // stored values at or below the new value: a prefix of the sorted row
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (CNT_W'(i) < count_r) && (cells_r[i] <= req_value_r);
    end
  end

  // one pass over the row of cells for the request in the stage
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_nxt[i] = cells_r[i];
    end
    count_nxt      = count_r;
    dump_cnt_nxt   = dump_cnt_r;
    out_status_nxt = ST_OK;
    out_value_nxt  = '0;
    out_last_nxt   = 1'b1;

    unique case (action_t'(req_action_r))
      ACT_INSERT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          out_status_nxt = ST_FULL;
        end else begin
          // keep the prefix, drop the value in, shift the rest up one
          cells_nxt[0] = le[0] ? cells_r[0] : req_value_r;
          for (int i = 1; i < CAPACITY; i++) begin
            if (le[i]) begin
              cells_nxt[i] = cells_r[i];
            end else if (le[i-1]) begin
              cells_nxt[i] = req_value_r;
            end else begin
              cells_nxt[i] = cells_r[i-1];
            end
          end
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          out_status_nxt = ST_BAD_POS;
        end else begin
          // close the gap from the removed position upward
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CMP_W'(i) >= pos_ext) begin
              cells_nxt[i] = cells_r[i+1];
            end
          end
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_DUMP: begin
        if (count_r == '0) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          // emit the head cell and rotate the live part of the row by one;
          // after count steps the row is back in place
          out_status_nxt = ST_DUMP;
          out_value_nxt  = OUT_VAL_W'(head_raw);
          out_last_nxt   = dump_last;
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == cnt_m1) begin
              cells_nxt[i] = cells_r[0];
            end else if ((i < CAPACITY - 1) && (CNT_W'(i) < cnt_m1)) begin
              cells_nxt[i] = cells_r[(i < CAPACITY - 1) ? i + 1 : i];
            end
          end
          dump_cnt_nxt = dump_last ? '0 : dump_cnt_r + 1'b1;
        end
      end
      default: begin
        // unused action code: no change, plain ok
        out_status_nxt = ST_OK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      dump_cnt_r  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        req_valid_r <= 1'b1;
      end else if (req_done) begin
        req_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
        dump_cnt_r  <= dump_cnt_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: request fields, cells and result fields
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_action_r <= in_tuser;
      req_value_r  <= in_tdata[VALUE_BITS-1:0];
      req_pos_r    <= in_tdata[VALUE_BITS+POS_W-1:VALUE_BITS];
    end
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells_r[i] <= cells_nxt[i];
      end
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_count_r  <= OUT_CNT_W'(count_nxt);
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
